FILE: sv/tce_pkg.sv
// tce_pkg: shared types, codes and constants of the tftp client transfer engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tce_pkg;

    // field widths
    localparam int PORT_W    = 16;
    localparam int BLOCK_W   = 16;
    localparam int SIZE_W    = 25;
    localparam int LEN_W     = 10;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;

    // protocol constants
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam logic [PORT_W-1:0] TFTP_PORT = 16'd69;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_PORT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUT_FILE_SIZE = 2'd2;

    // configuration reset values
    localparam logic              MODE_RESET        = 1'b1;
    localparam logic [PORT_W-1:0] CLIENT_PORT_RESET = 16'd2000;
    localparam logic [SIZE_W-1:0] PUT_SIZE_RESET    = '0;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_RRQ  = 3'd1,
        KIND_WRQ  = 3'd2,
        KIND_ACK  = 3'd3,
        KIND_DATA = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } status_t;

    // item class decided by the front
    typedef enum logic [2:0] {
        CLS_START,
        CLS_IGNORE,
        CLS_ERROR,
        CLS_DATA,
        CLS_ACK,
        CLS_OTHER
    } cls_t;

    // queue entry handed from front to back
    typedef struct packed {
        cls_t               cls;
        logic [PORT_W-1:0]  sender_port;
        logic [BLOCK_W-1:0] block_field;
        logic [LEN_W-1:0]   length;
    } entry_t;

    // one result transaction
    typedef struct packed {
        logic               accepted;
        kind_t              send_kind;
        logic [PORT_W-1:0]  send_dest_port;
        logic [BLOCK_W-1:0] send_block;
        logic [SIZE_W-1:0]  send_offset;
        logic [LEN_W-1:0]   send_length;
        status_t            transfer_status;
        logic [SIZE_W-1:0]  received_size;
        logic [BLOCK_W-1:0] error_code;
    } result_t;

endpackage

FILE: sv/tce_front.sv
// tce_front: classifies incoming transactions into entries for the queue
// depends on tce_pkg
`timescale 1ns / 1ps

module tce_front (
    input  logic                      s_action,
    input  logic                      s_is_ipv4_udp,
    input  logic [tce_pkg::PORT_W-1:0]  s_dest_port,
    input  logic [tce_pkg::PORT_W-1:0]  s_source_port,
    input  logic [15:0]               s_opcode,
    input  logic [tce_pkg::BLOCK_W-1:0] s_block_field,
    input  logic [tce_pkg::LEN_W-1:0]   s_payload_length,
    input  logic [tce_pkg::PORT_W-1:0]  client_port,
    output tce_pkg::entry_t           entry
);
    import tce_pkg::*;

    // opcode and port match
    always_comb begin
        entry.sender_port = s_source_port;
        entry.block_field = s_block_field;
        // oversized payload counts as one full block
        entry.length = (s_payload_length > LEN_W'(BLOCK_BYTES)) ?
                       LEN_W'(BLOCK_BYTES) : s_payload_length;
        if (s_action == 1'b0) begin
            entry.cls = CLS_START;
        end else if (!s_is_ipv4_udp || s_dest_port != client_port) begin
            entry.cls = CLS_IGNORE;
        end else begin
            case (s_opcode)
                OP_ERROR: entry.cls = CLS_ERROR;
                OP_DATA:  entry.cls = CLS_DATA;
                OP_ACK:   entry.cls = CLS_ACK;
                default:  entry.cls = CLS_OTHER;
            endcase
        end
    end

endmodule

FILE: sv/tce_queue.sv
// tce_queue: short register queue between the front and the back
// depends on tce_pkg
`timescale 1ns / 1ps

module tce_queue #(
    parameter int DEPTH = tce_pkg::QUEUE_DEPTH   // at least 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tce_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output tce_pkg::entry_t head_entry
);
    import tce_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/tce_back.sv
// tce_back: transfer state and result register, executes queued transactions
// depends on tce_pkg
`timescale 1ns / 1ps

module tce_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  tce_pkg::entry_t            head_entry,
    output logic                       pop,
    input  logic                       transfer_mode,
    input  logic [tce_pkg::SIZE_W-1:0] put_file_size,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tce_pkg::result_t           result
);
    import tce_pkg::*;

    logic [BLOCK_W-1:0] expected_block_reg, expected_block_next;
    logic [PORT_W-1:0]  peer_port_reg, peer_port_next;
    logic [SIZE_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [BLOCK_W-1:0] last_block_reg, last_block_next;
    status_t            status_reg, status_next;
    logic               valid_reg;
    result_t            result_reg, result_next;

    logic               running;
    logic               block_hit;
    logic [BLOCK_W-1:0] prev_block;
    logic [BLOCK_W-1:0] block_inc;
    logic [LEN_W-1:0]   put_len;

    assign pop     = head_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign result  = result_reg;

    assign running    = (status_reg == ST_RUN);
    assign block_hit  = (head_entry.block_field == expected_block_reg);
    assign prev_block = expected_block_reg - 1'b1;
    assign block_inc  = expected_block_reg + 1'b1;
    assign put_len    = (bytes_left_reg > SIZE_W'(BLOCK_BYTES)) ?
                        LEN_W'(BLOCK_BYTES) : bytes_left_reg[LEN_W-1:0];

    // transaction execution
    always_comb begin
        expected_block_next = expected_block_reg;
        peer_port_next      = peer_port_reg;
        bytes_left_next     = bytes_left_reg;
        last_block_next     = last_block_reg;
        status_next         = status_reg;
        result_next         = '0;
        result_next.send_kind = KIND_NONE;
        case (head_entry.cls)
            CLS_START: begin
                peer_port_next = TFTP_PORT;
                status_next    = ST_RUN;
                result_next.send_dest_port = TFTP_PORT;
                if (transfer_mode) begin
                    expected_block_next   = BLOCK_W'(1);
                    bytes_left_next       = '0;
                    last_block_next       = '0;
                    result_next.send_kind = KIND_RRQ;
                end else begin
                    expected_block_next   = '0;
                    bytes_left_next       = put_file_size;
                    last_block_next       = BLOCK_W'(put_file_size >> BLOCK_SHIFT) + 1'b1;
                    result_next.send_kind = KIND_WRQ;
                end
            end
            CLS_ERROR: begin
                if (running) begin
                    status_next            = ST_ERR;
                    result_next.accepted   = 1'b1;
                    result_next.error_code = head_entry.block_field;
                end
            end
            CLS_DATA, CLS_ACK, CLS_OTHER: begin
                if (running) begin
                    // any matching non-error packet teaches the server port
                    peer_port_next = head_entry.sender_port;
                    if (transfer_mode) begin
                        if (head_entry.cls == CLS_DATA && block_hit) begin
                            result_next.accepted       = 1'b1;
                            result_next.send_kind      = KIND_ACK;
                            result_next.send_dest_port = peer_port_next;
                            result_next.send_block     = expected_block_reg;
                            expected_block_next        = block_inc;
                            // short block ends the get
                            if (head_entry.length != LEN_W'(BLOCK_BYTES)) begin
                                status_next = ST_DONE;
                                result_next.received_size =
                                    SIZE_W'({prev_block, BLOCK_SHIFT'(0)})
                                    + SIZE_W'(head_entry.length);
                            end
                        end
                    end else begin
                        if (head_entry.cls == CLS_ACK && block_hit) begin
                            result_next.accepted = 1'b1;
                            if (expected_block_reg == last_block_reg) begin
                                status_next = ST_DONE;
                            end else begin
                                expected_block_next        = block_inc;
                                result_next.send_kind      = KIND_DATA;
                                result_next.send_dest_port = peer_port_next;
                                result_next.send_block     = block_inc;
                                result_next.send_offset    = put_file_size - bytes_left_reg;
                                result_next.send_length    = put_len;
                                bytes_left_next            = bytes_left_reg - SIZE_W'(put_len);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        result_next.transfer_status = status_next;
    end

    // transfer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_block_reg <= '0;
            peer_port_reg      <= TFTP_PORT;
            bytes_left_reg     <= '0;
            last_block_reg     <= '0;
            status_reg         <= ST_IDLE;
        end else if (pop) begin
            expected_block_reg <= expected_block_next;
            peer_port_reg      <= peer_port_next;
            bytes_left_reg     <= bytes_left_next;
            last_block_reg     <= last_block_next;
            status_reg         <= status_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: sv/tftp_client_transfer_engine.sv
// tftp_client_transfer_engine: top level, configuration registers and wiring
// depends on tce_pkg, tce_front, tce_queue, tce_back
//
// usage: the s_ channel carries one transaction per start command or received
// packet header; the m_ channel returns exactly one result transaction for each.
// configuration is written through cfg_wr_en / cfg_index / cfg_wdata while the
// block is idle: index 0 transfer mode, 1 client port, 2 put file size.
// a result passes through the queue and then the result register, which the
// back loads when it pops the entry, before it shows on the m_ channel.
// throughput: one transaction per cycle unless the receiver stalls; the back
// executes each queued entry with one compare-and-update of the transfer state,
// and the queue of QUEUE_DEPTH entries lets input keep flowing while a result waits.
// when the receiver stalls, the result register holds, the back stops, and
// s_ready drops once the queue is full.
// reset (aresetn low, synchronous) empties the queue and result register and
// returns the transfer to idle with the server port set to 69.
`timescale 1ns / 1ps

module tftp_client_transfer_engine #(
    parameter int QUEUE_DEPTH = tce_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          cfg_wr_en,
    input  logic [tce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]     cfg_wdata,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic                          s_is_ipv4_udp,
    input  logic [tce_pkg::PORT_W-1:0]    s_dest_port,
    input  logic [tce_pkg::PORT_W-1:0]    s_source_port,
    input  logic [15:0]                   s_opcode,
    input  logic [tce_pkg::BLOCK_W-1:0]   s_block_field,
    input  logic [tce_pkg::LEN_W-1:0]     s_payload_length,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_accepted,
    output logic [2:0]                    m_send_kind,
    output logic [tce_pkg::PORT_W-1:0]    m_send_dest_port,
    output logic [tce_pkg::BLOCK_W-1:0]   m_send_block,
    output logic [tce_pkg::SIZE_W-1:0]    m_send_offset,
    output logic [tce_pkg::LEN_W-1:0]     m_send_length,
    output logic [1:0]                    m_transfer_status,
    output logic [tce_pkg::SIZE_W-1:0]    m_received_size,
    output logic [tce_pkg::BLOCK_W-1:0]   m_error_code
);
    import tce_pkg::*;

    logic              transfer_mode_reg;
    logic [PORT_W-1:0] client_port_reg;
    logic [SIZE_W-1:0] put_file_size_reg;

    entry_t  front_entry;
    entry_t  head_entry;
    logic    queue_full;
    logic    head_valid;
    logic    pop;
    result_t result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transfer_mode_reg <= MODE_RESET;
            client_port_reg   <= CLIENT_PORT_RESET;
            put_file_size_reg <= PUT_SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TRANSFER_MODE: transfer_mode_reg <= cfg_wdata[0];
                REG_CLIENT_PORT:   client_port_reg   <= cfg_wdata[PORT_W-1:0];
                REG_PUT_FILE_SIZE: put_file_size_reg <= cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: classify
    tce_front u_front (
        .s_action         (s_action),
        .s_is_ipv4_udp    (s_is_ipv4_udp),
        .s_dest_port      (s_dest_port),
        .s_source_port    (s_source_port),
        .s_opcode         (s_opcode),
        .s_block_field    (s_block_field),
        .s_payload_length (s_payload_length),
        .client_port      (client_port_reg),
        .entry            (front_entry)
    );

    assign s_ready = !queue_full;

    // queue between front and back
    tce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && s_ready),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back: execute
    tce_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .transfer_mode (transfer_mode_reg),
        .put_file_size (put_file_size_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .result        (result)
    );

    assign m_accepted        = result.accepted;
    assign m_send_kind       = result.send_kind;
    assign m_send_dest_port  = result.send_dest_port;
    assign m_send_block      = result.send_block;
    assign m_send_offset     = result.send_offset;
    assign m_send_length     = result.send_length;
    assign m_transfer_status = result.transfer_status;
    assign m_received_size   = result.received_size;
    assign m_error_code      = result.error_code;

endmodule

FILE: sv/tce_checker.sv
// tce_checker: port-level assertions on the result channel of the engine
// depends on tce_pkg; bound to tftp_client_transfer_engine
`timescale 1ns / 1ps

module tce_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_accepted,
    input logic [2:0]                  m_send_kind,
    input logic [tce_pkg::PORT_W-1:0]  m_send_dest_port,
    input logic [tce_pkg::LEN_W-1:0]   m_send_length,
    input logic [1:0]                  m_transfer_status,
    input logic [tce_pkg::BLOCK_W-1:0] m_error_code
);
    import tce_pkg::*;

    // stalled result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a request starts a run toward the well-known server port
    a_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_send_kind == KIND_RRQ || m_send_kind == KIND_WRQ) |->
        !m_accepted && m_transfer_status == ST_RUN && m_send_dest_port == TFTP_PORT)
        else $error("request result inconsistent");

    // an ack or data packet is only sent for an accepted packet
    a_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_send_kind == KIND_ACK || m_send_kind == KIND_DATA) |-> m_accepted)
        else $error("reply sent for rejected packet");

    // error code only with server error status
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != '0 |-> m_accepted && m_transfer_status == ST_ERR)
        else $error("error code without error status");

    // data blocks never exceed one block, and only data results carry a length
    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_send_length <= LEN_W'(BLOCK_BYTES) &&
        (m_send_kind == KIND_DATA || m_send_length == '0))
        else $error("bad send length");

endmodule

bind tftp_client_transfer_engine tce_checker u_tce_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_accepted        (m_accepted),
    .m_send_kind       (m_send_kind),
    .m_send_dest_port  (m_send_dest_port),
    .m_send_length     (m_send_length),
    .m_transfer_status (m_transfer_status),
    .m_error_code      (m_error_code)
);

FILE: dv/tftp_client_transfer_engine_tb.sv
// tftp_client_transfer_engine_tb: self-checking testbench of the tftp client transfer engine
// depends on tce_pkg and tftp_client_transfer_engine; predicts every reply transaction
`timescale 1ns / 1ps

module tftp_client_transfer_engine_tb;
    import tce_pkg::*;

    // item action codes
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_PACKET = 1'b1;
    localparam logic [SIZE_W-1:0] PUT_SIZE_MAX = 25'd33553919;

    // one request transaction
    typedef struct {
        logic               action;
        logic               udp_ok;
        logic [PORT_W-1:0]  dport;
        logic [PORT_W-1:0]  sport;
        logic [15:0]        opcode;
        logic [BLOCK_W-1:0] blk;
        logic [LEN_W-1:0]   plen;
    } pkt_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic s_is_ipv4_udp = 1'b0;
    logic [PORT_W-1:0] s_dest_port = '0;
    logic [PORT_W-1:0] s_source_port = '0;
    logic [15:0] s_opcode = '0;
    logic [BLOCK_W-1:0] s_block_field = '0;
    logic [LEN_W-1:0] s_payload_length = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_accepted;
    logic [2:0] m_send_kind;
    logic [PORT_W-1:0] m_send_dest_port;
    logic [BLOCK_W-1:0] m_send_block;
    logic [SIZE_W-1:0] m_send_offset;
    logic [LEN_W-1:0] m_send_length;
    logic [1:0] m_transfer_status;
    logic [SIZE_W-1:0] m_received_size;
    logic [BLOCK_W-1:0] m_error_code;

    // idle percentages of sender and receiver
    int send_idle_pct = 6;
    int recv_idle_pct = 62;
    int mismatch_count = 0;

    // predicted replies, oldest first
    result_t pending_replies[$];
    result_t head_reply;

    // predictor copy of configuration and transfer state
    logic               mode_cfg = MODE_RESET;
    logic [PORT_W-1:0]  port_cfg = CLIENT_PORT_RESET;
    logic [SIZE_W-1:0]  size_cfg = PUT_SIZE_RESET;
    logic [BLOCK_W-1:0] exp_blk = '0;
    logic [PORT_W-1:0]  peer_q = TFTP_PORT;
    logic [SIZE_W-1:0]  left_q = '0;
    logic [BLOCK_W-1:0] last_blk_q = '0;
    status_t            xfer_st = ST_IDLE;

    tftp_client_transfer_engine i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_is_ipv4_udp     (s_is_ipv4_udp),
        .s_dest_port       (s_dest_port),
        .s_source_port     (s_source_port),
        .s_opcode          (s_opcode),
        .s_block_field     (s_block_field),
        .s_payload_length  (s_payload_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_send_kind       (m_send_kind),
        .m_send_dest_port  (m_send_dest_port),
        .m_send_block      (m_send_block),
        .m_send_offset     (m_send_offset),
        .m_send_length     (m_send_length),
        .m_transfer_status (m_transfer_status),
        .m_received_size   (m_received_size),
        .m_error_code      (m_error_code)
    );

    // clock
    always #5 aclk = ~aclk;

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // transfer engine prediction for one transaction
    function automatic result_t tftp_predict(input pkt_t p);
        result_t r;
        logic [LEN_W-1:0] len;
        logic [SIZE_W-1:0] chunk;
        logic [BLOCK_W-1:0] prev;
        logic [31:0] size_sum;
        r = '0;
        r.send_kind = KIND_NONE;
        if (p.action == ACT_START) begin
            peer_q = TFTP_PORT;
            xfer_st = ST_RUN;
            if (mode_cfg) begin
                exp_blk = 16'd1;
                left_q = '0;
                last_blk_q = '0;
                r.send_kind = KIND_RRQ;
            end else begin
                exp_blk = '0;
                left_q = size_cfg;
                last_blk_q = BLOCK_W'((size_cfg >> BLOCK_SHIFT) + 1);
                r.send_kind = KIND_WRQ;
            end
            r.send_dest_port = TFTP_PORT;
        end else if (xfer_st == ST_RUN && p.udp_ok && p.dport == port_cfg) begin
            if (p.opcode == OP_ERROR) begin
                xfer_st = ST_ERR;
                r.accepted = 1'b1;
                r.error_code = p.blk;
            end else begin
                // server port is learned even from a rejected packet
                peer_q = p.sport;
                if (mode_cfg) begin
                    if (p.opcode == OP_DATA && p.blk == exp_blk) begin
                        len = (p.plen > BLOCK_BYTES) ? LEN_W'(BLOCK_BYTES) : p.plen;
                        r.accepted = 1'b1;
                        r.send_kind = KIND_ACK;
                        r.send_dest_port = peer_q;
                        r.send_block = exp_blk;
                        // short block ends the get and reports the size
                        if (len != BLOCK_BYTES) begin
                            prev = exp_blk - 16'd1;
                            xfer_st = ST_DONE;
                            size_sum = {16'd0, prev} * BLOCK_BYTES + {22'd0, len};
                            r.received_size = size_sum[SIZE_W-1:0];
                        end
                        exp_blk = exp_blk + 16'd1;
                    end
                end else if (p.opcode == OP_ACK && p.blk == exp_blk) begin
                    r.accepted = 1'b1;
                    if (exp_blk == last_blk_q) begin
                        xfer_st = ST_DONE;
                    end else begin
                        chunk = (left_q > BLOCK_BYTES) ? SIZE_W'(BLOCK_BYTES) : left_q;
                        exp_blk = exp_blk + 16'd1;
                        r.send_kind = KIND_DATA;
                        r.send_dest_port = peer_q;
                        r.send_block = exp_blk;
                        r.send_offset = size_cfg - left_q;
                        r.send_length = chunk[LEN_W-1:0];
                        left_q = left_q - chunk;
                    end
                end
            end
        end
        r.transfer_status = xfer_st;
        return r;
    endfunction

    // compare one reply field
    task automatic check_field(input string name, input logic [SIZE_W-1:0] exp_v,
                               input logic [SIZE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v,
                     act_v);
        end
    endtask

    // reply checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected reply, expected none actual kind %0h", $time,
                         m_send_kind);
            end else begin
                head_reply = pending_replies.pop_front();
                check_field("accepted", SIZE_W'(head_reply.accepted), SIZE_W'(m_accepted));
                check_field("send_kind", SIZE_W'(head_reply.send_kind),
                            SIZE_W'(m_send_kind));
                check_field("send_dest_port", SIZE_W'(head_reply.send_dest_port),
                            SIZE_W'(m_send_dest_port));
                check_field("send_block", SIZE_W'(head_reply.send_block),
                            SIZE_W'(m_send_block));
                check_field("send_offset", head_reply.send_offset, m_send_offset);
                check_field("send_length", SIZE_W'(head_reply.send_length),
                            SIZE_W'(m_send_length));
                check_field("transfer_status", SIZE_W'(head_reply.transfer_status),
                            SIZE_W'(m_transfer_status));
                check_field("received_size", head_reply.received_size, m_received_size);
                check_field("error_code", SIZE_W'(head_reply.error_code),
                            SIZE_W'(m_error_code));
            end
        end
    end

    // send one request transaction and predict its reply
    task automatic send_item(input pkt_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= p.action;
        s_is_ipv4_udp    <= p.udp_ok;
        s_dest_port      <= p.dport;
        s_source_port    <= p.sport;
        s_opcode         <= p.opcode;
        s_block_field    <= p.blk;
        s_payload_length <= p.plen;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(tftp_predict(p));
    endtask

    // hold off until every reply has come and the pipeline is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TRANSFER_MODE: mode_cfg = val[0];
            REG_CLIENT_PORT:   port_cfg = val[PORT_W-1:0];
            REG_PUT_FILE_SIZE: size_cfg = val[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    function automatic pkt_t mk(input logic action, input logic udp_ok,
                                input logic [15:0] dport, input logic [15:0] sport,
                                input logic [15:0] opcode, input logic [15:0] blk,
                                input logic [LEN_W-1:0] plen);
        pkt_t p;
        p.action = action;
        p.udp_ok = udp_ok;
        p.dport = dport;
        p.sport = sport;
        p.opcode = opcode;
        p.blk = blk;
        p.plen = plen;
        return p;
    endfunction

    // mostly well-formed packet for the running transfer, with some noise
    function automatic pkt_t rand_packet(input logic [15:0] tid);
        pkt_t p;
        int r;
        p = mk(ACT_PACKET, $urandom_range(99) < 95, port_cfg, tid, '0, exp_blk,
               LEN_W'($urandom_range(0, 1023)));
        if ($urandom_range(99) >= 92) p.dport = 16'($urandom_range(0, 65535));
        if ($urandom_range(99) >= 80) p.sport = 16'($urandom_range(0, 65535));
        r = $urandom_range(99);
        if (r < 80)      p.opcode = mode_cfg ? OP_DATA : OP_ACK;
        else if (r < 86) p.opcode = mode_cfg ? OP_ACK : OP_DATA;
        else if (r < 90) p.opcode = OP_ERROR;
        else             p.opcode = 16'($urandom_range(0, 65535));
        r = $urandom_range(99);
        if (r >= 92)      p.blk = 16'($urandom_range(0, 65535));
        else if (r >= 85) p.blk = exp_blk + ($urandom_range(0, 1) ? 16'd1 : 16'hffff);
        if (mode_cfg) begin
            r = $urandom_range(99);
            if (r < 75)      p.plen = LEN_W'(BLOCK_BYTES);
            else if (r < 90) p.plen = LEN_W'($urandom_range(0, BLOCK_BYTES - 1));
        end
        return p;
    endfunction

    // idle filtering, get transfers, restart, error and oversized payload
    task automatic test_get_directed();
        send_item(mk(ACT_PACKET, 1'b1, CLIENT_PORT_RESET, 16'd69, OP_DATA, 16'd1, 10'd512));
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b0, 16'd2000, 16'd69, OP_DATA, 16'd1, 10'd512));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2001, 16'd69, OP_DATA, 16'd1, 10'd512));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'hffff, OP_ACK, 16'd1, 10'd512));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'd1234, OP_DATA, 16'd2, 10'd512));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'hbeef, OP_DATA, 16'd1, 10'h3ff));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'hbeef, OP_DATA, 16'd2, 10'd0));
        // restart after the get has ended, then restart while busy
        send_item(mk(ACT_START, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'd0, OP_DATA, 16'd1, 10'd512));
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'd5000, OP_DATA, 16'd1, 10'd511));
        // server error ends the transfer; later packets are ignored
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'd5000, OP_ERROR, 16'hffff, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'd2000, 16'd5000, OP_DATA, 16'd1, 10'd100));
    endtask

    // put transfers: partial last block, empty file, largest file, error
    task automatic test_put_directed();
        write_reg(REG_TRANSFER_MODE, '0);
        write_reg(REG_CLIENT_PORT, 25'd65535);
        write_reg(REG_PUT_FILE_SIZE, 25'd1025);
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7000, OP_DATA, 16'd0, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7000, OP_ACK, 16'd0, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7000, OP_ACK, 16'd1, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7000, OP_ACK, 16'd2, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7000, OP_ACK, 16'd3, 10'd0));
        write_reg(REG_PUT_FILE_SIZE, '0);
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7001, OP_ACK, 16'd0, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7001, OP_ACK, 16'd1, 10'd0));
        write_reg(REG_PUT_FILE_SIZE, PUT_SIZE_MAX);
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7002, OP_ACK, 16'd0, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, 16'hffff, 16'd7002, OP_ERROR, 16'd0, 10'd0));
    endtask

    // put with an all-ones file size so the final block number wraps to zero
    task automatic test_block_wrap();
        write_reg(REG_TRANSFER_MODE, 25'd0);
        write_reg(REG_PUT_FILE_SIZE, 25'h1ffffff);
        send_item(mk(ACT_START, 1'b0, '0, '0, '0, '0, '0));
        send_item(mk(ACT_PACKET, 1'b1, port_cfg, 16'd4242, OP_ACK, 16'd0, 10'd0));
        send_item(mk(ACT_PACKET, 1'b1, port_cfg, 16'd4242, OP_ACK, 16'd1, 10'd0));
    endtask

    // random transfers under random configurations
    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst;
        int r;
        logic [15:0] tid;
        pkt_t p;
        sent = 0;
        while (sent < n_items) begin
            write_reg(REG_TRANSFER_MODE, CFG_W'($urandom_range(0, 1)));
            r = $urandom_range(99);
            if (r < 15)      write_reg(REG_CLIENT_PORT, 25'd2000);
            else if (r < 30) write_reg(REG_CLIENT_PORT, 25'd65535);
            else             write_reg(REG_CLIENT_PORT, CFG_W'($urandom_range(2000, 65535)));
            r = $urandom_range(99);
            if (r < 60)      write_reg(REG_PUT_FILE_SIZE, CFG_W'($urandom_range(0, 3000)));
            else if (r < 80) write_reg(REG_PUT_FILE_SIZE, CFG_W'(512 * $urandom_range(0, 6)));
            else if (r < 90) write_reg(REG_PUT_FILE_SIZE, PUT_SIZE_MAX);
            else             write_reg(REG_PUT_FILE_SIZE, CFG_W'($urandom_range(0, 33553919)));
            tid = 16'($urandom_range(0, 65535));
            p = rand_packet(tid);
            p.action = ACT_START;
            send_item(p);
            sent++;
            burst = 0;
            while (xfer_st == ST_RUN && burst < 40 && sent < n_items) begin
                r = $urandom_range(99);
                // mode flip mid-transfer takes effect at once
                if (r < 2) write_reg(REG_TRANSFER_MODE, CFG_W'(~mode_cfg));
                p = rand_packet(tid);
                if (r >= 2 && r < 4) p.action = ACT_START;
                send_item(p);
                sent++;
                burst++;
            end
            // stray packets after the transfer has ended
            if ($urandom_range(99) < 20 && sent < n_items) begin
                send_item(rand_packet(tid));
                sent++;
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_get_directed();
        test_put_directed();
        test_random_traffic(235);
        send_idle_pct = 62;
        recv_idle_pct = 6;
        test_random_traffic(235);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_block_wrap();
        test_random_traffic(235);
        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
